@@ rtl/mlfd_pkg.sv @@
// shared types and constants for the marker/length frame deframer
// no dependencies; imported by every module of the block

package mlfd_pkg;

    // parser phase codes
    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_START   = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_MARK2   = 3'd4;
    localparam logic [2:0] PH_END     = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_START  = 2'd0;
    localparam logic [1:0] CFG_MARKER = 2'd1;
    localparam logic [1:0] CFG_END    = 2'd2;

    // configuration register reset values
    localparam logic [7:0] START_RST  = 8'd2;
    localparam logic [7:0] MARKER_RST = 8'd27;
    localparam logic [7:0] END_RST    = 8'd3;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] marker_byte;
        logic [7:0] end_byte;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic [1:0] kind;
    } res_t;

endpackage

@@ rtl/mlfd_cfg_regs.sv @@
// configuration registers: start, marker and end byte values
// depends on mlfd_pkg

module mlfd_cfg_regs
    import mlfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [1:0] wr_index,
    input  logic [7:0] wr_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_START:  cfg_next.start_byte  = wr_data;
                CFG_MARKER: cfg_next.marker_byte = wr_data;
                CFG_END:    cfg_next.end_byte    = wr_data;
                default:    cfg_next = cfg_reg; // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte  <= START_RST;
            cfg_reg.marker_byte <= MARKER_RST;
            cfg_reg.end_byte    <= END_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/mlfd_parser.sv @@
// frame parser: phase and byte counter, one byte per step
// depends on mlfd_pkg

module mlfd_parser
    import mlfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output res_t       res
);

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic [7:0] left_reg;
    logic [7:0] left_next;

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        res        = '0;
        case (phase_reg)
            PH_START:
            begin
                // marker wins when start and marker are equal
                if (rx_byte == cfg.marker_byte)
                    phase_next = PH_LENGTH;
                else if (rx_byte == cfg.start_byte)
                    phase_next = PH_START;
                else
                    phase_next = PH_HUNT;
            end
            PH_LENGTH:
            begin
                left_next  = rx_byte;
                phase_next = (rx_byte == 8'd0) ? PH_MARK2 : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1)
                    phase_next = PH_MARK2;
                res.valid    = 1'b1;
                res.out_byte = rx_byte;
                res.kind     = KIND_DATA;
            end
            PH_MARK2:
            begin
                if (rx_byte == cfg.marker_byte)
                begin
                    phase_next = PH_END;
                end
                else
                begin
                    phase_next = PH_HUNT;
                    res.valid  = 1'b1;
                    res.kind   = KIND_BAD;
                end
            end
            PH_END:
            begin
                phase_next = PH_HUNT;
                res.valid  = 1'b1;
                res.kind   = (rx_byte == cfg.end_byte) ? KIND_OK : KIND_BAD;
            end
            default:
            begin
                // hunting, unused codes behave the same
                phase_next = (rx_byte == cfg.start_byte) ? PH_START : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            left_reg  <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

@@ rtl/marker_length_frame_deframer_unit.sv @@
// top level of the marker/length frame deframer
// depends on mlfd_pkg, mlfd_cfg_regs and mlfd_parser

// Receives a byte stream on the slave side and finds frames of the form
// start, marker, length L, L payload bytes, marker, end. Every payload byte
// is sent out as it arrives with tuser kind 0; after the trailer one more
// request reports kind 1 (trailer matched) or kind 2 (trailer mismatch,
// with zero data). A wrong header byte sends the parser back to hunting
// without any output. Timing: one byte per clock sustained while the
// master side takes results; a byte goes from the input register through
// the parser into the output register before its result is presented on
// the master side. The input register holds one byte while the output
// register is stalled, and the parser state advances only when a byte
// moves into the parser step.
// Configuration writes (start, marker, end byte) are always accepted and
// should be made only while the block is idle.

module marker_length_frame_deframer_unit
    import mlfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // receive stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] kind
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t       cfg;
    res_t       res;

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;

    // output register
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [1:0] out_kind_reg;

    logic       out_free;
    logic       step;
    logic       s_fire;

    assign cfg_ready = 1'b1;

    mlfd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // output slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    // the buffered byte is parsed when its result has somewhere to go
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step;
    assign s_fire   = s_tvalid && s_tready;

    mlfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_comb
    begin
        if (s_fire)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_comb
    begin
        if (out_free)
            out_valid_next = step && res.valid;
        else
            out_valid_next = out_valid_reg;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
            in_byte_reg <= s_tdata;
        if (out_free)
        begin
            out_byte_reg <= res.out_byte;
            out_kind_reg <= res.kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;

endmodule

@@ rtl/mlfd_checker.sv @@
// port-level checks for the marker/length frame deframer
// depends on mlfd_pkg; bound to marker_length_frame_deframer_unit

module mlfd_checker
    import mlfd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    // only the three defined kinds appear
    a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_DATA || m_tuser == KIND_OK || m_tuser == KIND_BAD))
        else $error("undefined result kind");

    // status requests carry zero data
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != KIND_DATA) |-> (m_tdata == 8'd0))
        else $error("status request with nonzero data");

    // a new result follows a receive request accepted earlier, through the input and output registers
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching receive request");

    // stalled request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result request changed");

endmodule

bind marker_length_frame_deframer_unit mlfd_checker u_mlfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ sim/tb_marker_length_frame_deframer_unit.sv @@
// self-checking testbench for marker_length_frame_deframer_unit
// depends on mlfd_pkg and the deframer rtl; a scoreboard class predicts each result

module tb_marker_length_frame_deframer_unit;
    import mlfd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_STALL  = 400;

    // one expected request on the result stream
    typedef struct {
        logic [7:0] data;
        logic [1:0] kind;
    } deframe_result_t;

    // frame parser mirror plus the queue of results it still owes
    class deframe_scoreboard;
        logic [7:0]      start_byte;
        logic [7:0]      marker_byte;
        logic [7:0]      end_byte;
        logic [2:0]      phase;
        logic [7:0]      bytes_left;
        deframe_result_t owed[$];
        int              errors;

        function new();
            start_byte  = START_RST;
            marker_byte = MARKER_RST;
            end_byte    = END_RST;
            phase       = PH_HUNT;
            bytes_left  = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_START:  start_byte  = val;
                CFG_MARKER: marker_byte = val;
                CFG_END:    end_byte    = val;
                default: ;
            endcase
        endfunction

        function void owe(logic [7:0] data, logic [1:0] kind);
            deframe_result_t r;
            r.data = data;
            r.kind = kind;
            owed = {owed, r};
        endfunction

        // advance the parser by one accepted byte
        function void note_rx(logic [7:0] b);
            case (phase)
                PH_START:
                    if (b == marker_byte)
                        phase = PH_LENGTH;
                    else if (b == start_byte)
                        phase = PH_START;
                    else
                        phase = PH_HUNT;
                PH_LENGTH:
                begin
                    bytes_left = b;
                    phase = (b == 8'd0) ? PH_MARK2 : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 8'd0)
                        phase = PH_MARK2;
                    owe(b, KIND_DATA);
                end
                PH_MARK2:
                    if (b == marker_byte)
                        phase = PH_END;
                    else
                    begin
                        phase = PH_HUNT;
                        owe(8'd0, KIND_BAD);
                    end
                PH_END:
                begin
                    phase = PH_HUNT;
                    owe(8'd0, (b == end_byte) ? KIND_OK : KIND_BAD);
                end
                default:
                    phase = (b == start_byte) ? PH_START : PH_HUNT;
            endcase
        endfunction

        function void check_result(logic [7:0] data, logic [1:0] kind);
            deframe_result_t r;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result data %h kind %0d", $time, data, kind);
                errors++;
                return;
            end
            r = owed.pop_front();
            if (data !== r.data)
            begin
                $display("%0t: data mismatch, expected %h actual %h", $time, r.data, data);
                errors++;
            end
            if (kind !== r.kind)
            begin
                $display("%0t: kind mismatch, expected %0d actual %0d", $time, r.kind, kind);
                errors++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    deframe_scoreboard sb = new();

    int  send_idle_pct;
    int  recv_idle_pct;
    int  bytes_sent;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  stall_armed;
    bit  stall_taken = 1'b0;

    marker_length_frame_deframer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 unit clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // result side ready: random back-pressure, plus one long hold-off
    // counted here so the sender keeps pushing into a full pipeline
    always @(posedge clk)
    begin
        if (stall_armed && !stall_taken)
        begin
            stall_left  = LONG_STALL;
            stall_taken = 1'b1;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // every accepted result request goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // offer one byte after zero or more idle cycles, and hold it until taken;
    // tvalid stays high afterwards so back-to-back bytes need no extra edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        sb.note_rx(b);
        bytes_sent++;
    endtask

    // stop sending, let every owed result arrive, then let the pipe settle
    // since bytes without a result may still be inside
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // write all three framing bytes while the block is idle
    task automatic set_framing(input logic [7:0] st, input logic [7:0] mk,
                               input logic [7:0] en);
        logic [7:0] vals [3];
        logic [1:0] idx [3];
        vals = '{st, mk, en};
        idx  = '{CFG_START, CFG_MARKER, CFG_END};
        drain();
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] other_than(input logic [7:0] v);
        return v ^ 8'($urandom_range(1, 255));
    endfunction

    // one frame with random content; mostly well formed, sometimes with
    // leading noise, a repeated start, a broken header or a broken trailer
    task automatic send_frame();
        logic [7:0] st;
        logic [7:0] mk;
        logic [7:0] len;
        int         pick;
        st = sb.start_byte;
        mk = sb.marker_byte;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        send_byte(st);
        if (st != mk && $urandom_range(0, 7) == 0)
            send_byte(st);
        if ($urandom_range(0, 9) == 0)
        begin
            // header byte that is not the marker
            send_byte(other_than(mk));
            return;
        end
        send_byte(mk);
        pick = $urandom_range(0, 39);
        if (pick == 0)
            len = 8'd255;
        else if (pick == 1)
            len = 8'($urandom_range(128, 255));
        else if (pick < 6)
            len = 8'd0;
        else
            len = 8'($urandom_range(1, 12));
        send_byte(len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)));
        // trailer, each half occasionally wrong
        send_byte(($urandom_range(0, 9) == 0) ? other_than(mk) : mk);
        send_byte(($urandom_range(0, 9) == 0) ? other_than(sb.end_byte) : sb.end_byte);
    endtask

    task automatic run_frames(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
            send_frame();
    endtask

    initial
    begin
        logic [7:0] directed[$];

        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_START;
        cfg_data    = '0;
        rst_n       = 1'b0;
        bytes_sent  = 0;
        stall_armed = 1'b0;
        send_idle_pct = 36;
        recv_idle_pct = 61;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset framing (start 2, marker 27, end 3):
        // good frame with extreme payload bytes, zero length frame,
        // repeated start then a wrong trailer marker, a start straight after
        // the bad trailer followed by a bad header byte, and a wrong end byte
        directed = '{8'd2, 8'd27, 8'd3, 8'h00, 8'hFF, 8'h80, 8'd27, 8'd3,
                     8'd2, 8'd27, 8'd0, 8'd27, 8'd3,
                     8'd2, 8'd2, 8'd27, 8'd1, 8'h55, 8'd4,
                     8'd2, 8'd5,
                     8'd2, 8'd27, 8'd0, 8'd27, 8'd9};
        foreach (directed[i])
            send_byte(directed[i]);

        // start equal to marker, end at the top of the range
        set_framing(8'h00, 8'h00, 8'hFF);
        send_idle_pct = 36;
        recv_idle_pct = 61;
        run_frames(350);

        set_framing(8'hFF, 8'hA5, 8'h00);
        send_idle_pct = 61;
        recv_idle_pct = 36;
        run_frames(350);

        // full rate both sides, with one long result-side hold-off
        set_framing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_armed <= 1'b1;
        run_frames(350);

        // all three framing bytes the same
        set_framing(8'hFF, 8'hFF, 8'hFF);
        run_frames(350);

        drain();
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
